>>> rtl/ssr_pkg.sv
// Shared widths, constants and register indexes for the servo ramp unit.
package ssr_pkg;

  // Field widths.
  localparam int DUTY_BITS = 14;
  localparam int ANGLE_W   = 8;
  localparam int TIME_W    = 16;

  // Full-scale angle in degrees and the floor-rounding offset for negative slopes.
  localparam int MAX_ANGLE = 180;
  localparam int ROUND_UP  = MAX_ANGLE - 1;

  // Width of angle * |duty span| plus the rounding offset.
  localparam int PROD_W = $clog2(MAX_ANGLE * ((1 << DUTY_BITS) - 1) + MAX_ANGLE + 1);

  // Serial step counts and counter widths.
  localparam int MUL_STEPS = ANGLE_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic CFG_DUTY_ZERO = 1'b0;
  localparam logic CFG_DUTY_FULL = 1'b1;

  // Configuration reset values.
  localparam logic [DUTY_BITS-1:0] DUTY_ZERO_RST = DUTY_BITS'(410);
  localparam logic [DUTY_BITS-1:0] DUTY_FULL_RST = DUTY_BITS'(2048);

  // Input kind codes.
  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

endpackage

>>> rtl/ssr_mul.sv
// Bit-serial shift-add multiplier: angle times duty span, one multiplier bit per cycle.
module ssr_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ssr_pkg::DUTY_BITS-1:0]      mcand,
  input  logic [ssr_pkg::ANGLE_W-1:0]        mplier,
  output logic                               busy,
  output logic                               done,
  output logic [ssr_pkg::PROD_W-1:0]         product
);

  logic [ssr_pkg::PROD_W-1:0]    mc;
  logic [ssr_pkg::ANGLE_W-1:0]   mp;
  logic [ssr_pkg::MUL_CNT_W-1:0] cnt;

  // Each cycle adds the shifted multiplicand when the low multiplier bit is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == ssr_pkg::MUL_CNT_W'(ssr_pkg::MUL_STEPS - 1));
      if (start) begin
        product <= '0;
        mc      <= ssr_pkg::PROD_W'(mcand);
        mp      <= mplier;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        if (mp[0]) begin
          product <= product + mc;
        end
        mc  <= {mc[ssr_pkg::PROD_W-2:0], 1'b0};
        mp  <= {1'b0, mp[ssr_pkg::ANGLE_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == ssr_pkg::MUL_CNT_W'(ssr_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/ssr_div.sv
// Bit-serial restoring divider: wide dividend by an 8-bit divisor, one quotient bit per cycle.
module ssr_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ssr_pkg::PROD_W-1:0]       dividend,
  input  logic [ssr_pkg::ANGLE_W-1:0]      divisor,
  output logic                             busy,
  output logic                             done,
  output logic [ssr_pkg::PROD_W-1:0]       quotient
);

  logic [ssr_pkg::ANGLE_W-1:0]   rem;
  logic [ssr_pkg::ANGLE_W-1:0]   sor;
  logic [ssr_pkg::DIV_CNT_W-1:0] cnt;
  logic [ssr_pkg::ANGLE_W:0]     trial;
  logic [ssr_pkg::ANGLE_W:0]     trial_sub;
  logic                          fits;

  // One trial subtraction of the divisor from the partial remainder.
  always_comb begin
    trial     = {rem, quotient[ssr_pkg::PROD_W-1]};
    trial_sub = trial - {1'b0, sor};
    fits      = (trial >= {1'b0, sor});
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == ssr_pkg::DIV_CNT_W'(ssr_pkg::DIV_STEPS - 1));
      if (start) begin
        quotient <= dividend;
        sor      <= divisor;
        rem      <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= fits ? trial_sub[ssr_pkg::ANGLE_W-1:0] : trial[ssr_pkg::ANGLE_W-1:0];
        quotient <= {quotient[ssr_pkg::PROD_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == ssr_pkg::DIV_CNT_W'(ssr_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/servo_slew_limited_ramp_unit.sv
// Servo ramp generator: move and tick handling, shared serial units and result register.
// A move with nonzero distance runs two 22-step divisions with an 8-step multiply between
// them; a stepping tick or a move to the present angle runs only the multiply and the last.
// A new beat is taken only in the idle state, which a tick that only counts never leaves;
// a result still held at the output stalls the next.
// Synchronous reset: idle at zero degrees, duty registers at 410 and 2048, output empty.
module servo_slew_limited_ramp_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [ssr_pkg::DUTY_BITS-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [ssr_pkg::ANGLE_W-1:0]       goal_deg,
  input  logic [ssr_pkg::TIME_W-1:0]        travel_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssr_pkg::DUTY_BITS-1:0]     duty,
  output logic [ssr_pkg::ANGLE_W-1:0]       angle_now,
  output logic                              done_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TPS,
    S_MUL,
    S_RND,
    S_EMIT
  } state_t;

  state_t state;

  logic [ssr_pkg::DUTY_BITS-1:0] duty_zero;
  logic [ssr_pkg::DUTY_BITS-1:0] duty_full;
  logic [ssr_pkg::ANGLE_W-1:0]   present_angle;
  logic [ssr_pkg::ANGLE_W-1:0]   goal_angle;
  logic                          moving;
  logic [ssr_pkg::TIME_W-1:0]    ticks_per_step;
  logic [ssr_pkg::TIME_W-1:0]    tick_count;
  logic [ssr_pkg::ANGLE_W-1:0]   res_angle;
  logic                          res_done;

  logic                          mul_start;
  logic                          mul_busy;
  logic                          mul_done;
  logic [ssr_pkg::PROD_W-1:0]    mul_product;
  logic                          div_start;
  logic                          div_busy;
  logic                          div_done;
  logic [ssr_pkg::PROD_W-1:0]    div_dvd;
  logic [ssr_pkg::ANGLE_W-1:0]   div_sor;
  logic [ssr_pkg::PROD_W-1:0]    div_quot;

  logic                          accept;
  logic [ssr_pkg::ANGLE_W-1:0]   tgt_clamped;
  logic [ssr_pkg::ANGLE_W-1:0]   dist_deg;
  logic [ssr_pkg::TIME_W-1:0]    tick_inc;
  logic [ssr_pkg::ANGLE_W-1:0]   step_angle;
  logic                          span_neg;
  logic [ssr_pkg::DUTY_BITS-1:0] span_mag;
  logic [ssr_pkg::DUTY_BITS-1:0] duty_quot;
  logic [ssr_pkg::DUTY_BITS-1:0] duty_next;
  logic                          out_free;

  // Input handshake and the per-beat decode of a move or a tick.
  always_comb begin
    in_stall    = (state != S_IDLE);
    accept      = in_valid && !in_stall;
    tgt_clamped = (goal_deg > ssr_pkg::ANGLE_W'(ssr_pkg::MAX_ANGLE))
                  ? ssr_pkg::ANGLE_W'(ssr_pkg::MAX_ANGLE) : goal_deg;
    dist_deg    = (tgt_clamped > present_angle) ? tgt_clamped - present_angle
                                                : present_angle - tgt_clamped;
    tick_inc    = tick_count + 1'b1;
    if (goal_angle > present_angle) begin
      step_angle = present_angle + 1'b1;
    end else if (goal_angle < present_angle) begin
      step_angle = present_angle - 1'b1;
    end else begin
      step_angle = present_angle;
    end
  end

  // Duty span sign and magnitude; a falling span rounds its quotient up, then subtracts.
  always_comb begin
    span_neg  = (duty_full < duty_zero);
    span_mag  = span_neg ? duty_zero - duty_full : duty_full - duty_zero;
    duty_quot = div_quot[ssr_pkg::DUTY_BITS-1:0];
    duty_next = span_neg ? duty_zero - duty_quot : duty_zero + duty_quot;
    out_free  = !out_valid || !out_stall;
  end

  // Each serial unit is started once on the first cycle of a state that needs it.
  always_comb begin
    mul_start = (state == S_MUL) && !mul_busy && !mul_done;
    div_start = ((state == S_TPS) || (state == S_RND)) && !div_busy && !div_done;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_zero <= ssr_pkg::DUTY_ZERO_RST;
      duty_full <= ssr_pkg::DUTY_FULL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ssr_pkg::CFG_DUTY_ZERO: duty_zero <= cfg_data;
        ssr_pkg::CFG_DUTY_FULL: duty_full <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: ramp state, serial unit operands and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      present_angle  <= '0;
      goal_angle     <= '0;
      moving         <= 1'b0;
      ticks_per_step <= '0;
      tick_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == ssr_pkg::KIND_MOVE) begin
              goal_angle <= tgt_clamped;
              tick_count <= '0;
              res_angle  <= present_angle;
              if (dist_deg == '0) begin
                moving         <= 1'b0;
                ticks_per_step <= '0;
                res_done       <= 1'b1;
                state          <= S_MUL;
              end else begin
                moving    <= 1'b1;
                res_done  <= 1'b0;
                div_dvd   <= ssr_pkg::PROD_W'(travel_ms);
                div_sor   <= dist_deg;
                state     <= S_TPS;
              end
            end else if (moving) begin
              if (tick_inc < ticks_per_step) begin
                tick_count <= tick_inc;
              end else begin
                tick_count    <= '0;
                present_angle <= step_angle;
                res_angle     <= step_angle;
                res_done      <= (step_angle == goal_angle);
                moving        <= (step_angle != goal_angle);
                state         <= S_MUL;
              end
            end
          end
        end
        S_TPS: begin
          if (div_done) begin
            ticks_per_step <= div_quot[ssr_pkg::TIME_W-1:0];
            state          <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            div_dvd   <= span_neg ? mul_product + ssr_pkg::PROD_W'(ssr_pkg::ROUND_UP)
                                  : mul_product;
            div_sor   <= ssr_pkg::ANGLE_W'(ssr_pkg::MAX_ANGLE);
            state     <= S_RND;
          end
        end
        S_RND: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            duty      <= duty_next;
            angle_now <= res_angle;
            done_res  <= res_done;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ssr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (span_mag),
    .mplier  (res_angle),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_product)
  );

  ssr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_sor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // The angle never leaves the servo range.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    present_angle <= ssr_pkg::ANGLE_W'(ssr_pkg::MAX_ANGLE))
    else $error("present angle beyond full scale");

  // A ramp in progress has not yet reached its goal.
  a_moving_goal: assert property (@(posedge clk) disable iff (rst)
    moving |-> (present_angle != goal_angle))
    else $error("moving while already at the goal");

  // An idle ramp holds no partial step count.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !moving |-> (tick_count == '0))
    else $error("tick count left over while idle");

  // The two serial units never run at the same time.
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  // A stalled result beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(duty) && $stable(angle_now)
                                  && $stable(done_res)))
    else $error("result beat changed while stalled");

endmodule

>>> test/ssr_ramp_checker.sv
// Checker for the servo ramp unit: tracks its channels, predicts every result and compares.
module ssr_ramp_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [ssr_pkg::DUTY_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          kind,
  input  logic [ssr_pkg::ANGLE_W-1:0]   goal_deg,
  input  logic [ssr_pkg::TIME_W-1:0]    travel_ms,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ssr_pkg::DUTY_BITS-1:0] duty,
  input  logic [ssr_pkg::ANGLE_W-1:0]   angle_now,
  input  logic                          done_res,
  input  logic                          end_check,
  output int                            fail_count,
  output int                            checked_count,
  output int                            pending
);

  // One expected output beat.
  typedef struct packed {
    logic [ssr_pkg::DUTY_BITS-1:0] pwm;
    logic [ssr_pkg::ANGLE_W-1:0]   deg;
    logic                          at_goal;
  } servo_pos_t;

  servo_pos_t pos_q[$];

  // Shadow copy of the duty registers and of the ramp state.
  logic [ssr_pkg::DUTY_BITS-1:0] zero_duty;
  logic [ssr_pkg::DUTY_BITS-1:0] full_duty;
  logic [ssr_pkg::ANGLE_W-1:0]   cur_angle;
  logic [ssr_pkg::ANGLE_W-1:0]   goal_angle;
  logic                          ramping;
  logic [ssr_pkg::TIME_W-1:0]    step_ticks;
  logic [ssr_pkg::TIME_W-1:0]    tick_cnt;

  // Prints a mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("ramp check: %s (at %0t)", msg, $time);
    fail_count++;
  endtask

  // Queues the result for angle a. The duty is linear between the two registers and
  // floored toward minus infinity, so a falling span rounds down as well.
  task automatic queue_position(input logic [ssr_pkg::ANGLE_W-1:0] a, input logic reached);
    longint     span;
    longint     prod;
    longint     quot;
    servo_pos_t p;
    span = longint'(full_duty) - longint'(zero_duty);
    prod = longint'(a) * span;
    quot = prod / ssr_pkg::MAX_ANGLE;
    if ((prod < 0) && ((prod % ssr_pkg::MAX_ANGLE) != 0)) begin
      quot = quot - 1;
    end
    p.pwm     = ssr_pkg::DUTY_BITS'(longint'(zero_duty) + quot);
    p.deg     = a;
    p.at_goal = reached;
    pos_q.push_back(p);
  endtask

  // Advances the ramp state by one accepted input beat.
  task automatic predict_ramp(input logic k, input logic [ssr_pkg::ANGLE_W-1:0] tgt,
                              input logic [ssr_pkg::TIME_W-1:0] tms);
    logic [ssr_pkg::ANGLE_W-1:0] goal;
    logic [ssr_pkg::ANGLE_W-1:0] dist_deg;
    if (k == ssr_pkg::KIND_MOVE) begin
      goal = (tgt > ssr_pkg::MAX_ANGLE) ? ssr_pkg::ANGLE_W'(ssr_pkg::MAX_ANGLE) : tgt;
      dist_deg = (goal > cur_angle) ? goal - cur_angle : cur_angle - goal;
      goal_angle = goal;
      tick_cnt   = '0;
      // A move to the present angle finishes at once.
      if (dist_deg == 0) begin
        ramping    = 1'b0;
        step_ticks = '0;
        queue_position(cur_angle, 1'b1);
      end else begin
        step_ticks = tms / dist_deg;
        ramping    = 1'b1;
        queue_position(cur_angle, 1'b0);
      end
    end else if (ramping) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= step_ticks) begin
        tick_cnt = '0;
        if (goal_angle > cur_angle) begin
          cur_angle = cur_angle + 1'b1;
        end else if (goal_angle < cur_angle) begin
          cur_angle = cur_angle - 1'b1;
        end
        ramping = (cur_angle != goal_angle);
        queue_position(cur_angle, !ramping);
      end
    end
  endtask

  // Register writes, result comparison, then prediction for the input beat of this edge.
  always @(posedge clk) begin
    servo_pos_t want;
    if (rst) begin
      zero_duty  = ssr_pkg::DUTY_ZERO_RST;
      full_duty  = ssr_pkg::DUTY_FULL_RST;
      cur_angle  = '0;
      goal_angle = '0;
      ramping    = 1'b0;
      step_ticks = '0;
      tick_cnt   = '0;
      pos_q.delete();
    end else begin
      if (cfg_write === 1'b1) begin
        if (cfg_index == ssr_pkg::CFG_DUTY_ZERO) begin
          zero_duty = cfg_data;
        end else begin
          full_duty = cfg_data;
        end
      end

      // A result beat is matched against the oldest expectation.
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pos_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result duty %0d angle %0d done %0d",
                                    duty, angle_now, done_res));
        end else begin
          want = pos_q.pop_front();
          checked_count++;
          if (duty !== want.pwm) begin
            report_mismatch($sformatf("duty %0d, expected %0d at angle %0d",
                                      duty, want.pwm, want.deg));
          end
          if (angle_now !== want.deg) begin
            report_mismatch($sformatf("angle_now %0d, expected %0d", angle_now, want.deg));
          end
          if (done_res !== want.at_goal) begin
            report_mismatch($sformatf("done_res %0d, expected %0d at angle %0d",
                                      done_res, want.at_goal, want.deg));
          end
        end
      end

      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        predict_ramp(kind, goal_deg, travel_ms);
      end

      // Anything still queued at the end never arrived.
      if (end_check) begin
        while (pos_q.size() != 0) begin
          want = pos_q.pop_front();
          report_mismatch($sformatf("missing result duty %0d angle %0d done %0d",
                                    want.pwm, want.deg, want.at_goal));
        end
      end
    end
    pending = pos_q.size();
  end

endmodule

>>> test/servo_slew_limited_ramp_unit_tb.sv
// Testbench top for the servo ramp unit: clock, reset, stimulus, output stalls and verdict.
module servo_slew_limited_ramp_unit_tb;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 80;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          cfg_write    = 1'b0;
  logic                          cfg_index    = ssr_pkg::CFG_DUTY_ZERO;
  logic [ssr_pkg::DUTY_BITS-1:0] cfg_data     = '0;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic                          kind         = ssr_pkg::KIND_MOVE;
  logic [ssr_pkg::ANGLE_W-1:0]   goal_deg     = '0;
  logic [ssr_pkg::TIME_W-1:0]    travel_ms    = '0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic [ssr_pkg::DUTY_BITS-1:0] duty;
  logic [ssr_pkg::ANGLE_W-1:0]   angle_now;
  logic                          done_res;
  logic                          end_check    = 1'b0;

  int fail_count;
  int checked_count;
  int pending;

  // Shared between the sender and the receiver process.
  bit quiet     = 1'b0;
  bit long_hold = 1'b0;

  int beats_sent   = 0;
  int settings_run = 0;
  int aim          = 0;

  servo_slew_limited_ramp_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .goal_deg     (goal_deg),
    .travel_ms    (travel_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty         (duty),
    .angle_now    (angle_now),
    .done_res     (done_res)
  );

  ssr_ramp_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .goal_deg      (goal_deg),
    .travel_ms     (travel_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .duty          (duty),
    .angle_now     (angle_now),
    .done_res      (done_res),
    .end_check     (end_check),
    .fail_count    (fail_count),
    .checked_count (checked_count),
    .pending       (pending)
  );

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  // Output side: random stall runs, quiet stretches, and one long hold when asked.
  initial begin : receiver
    int run_len;
    int hold_left;
    int pick;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
        long_hold = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          out_stall <= 1'b0;
          run_len = $urandom_range(1, 8);
        end else if (pick < 95) begin
          out_stall <= 1'b1;
          run_len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          run_len = $urandom_range(15, 40);
        end
        repeat (run_len) @(posedge clk);
      end
    end
  end

  // Offers one input beat, holds it until accepted, then maybe idles a while.
  task automatic send_beat(input logic k, input logic [ssr_pkg::ANGLE_W-1:0] tgt,
                           input logic [ssr_pkg::TIME_W-1:0] tms);
    int pick;
    int gap;
    kind      <= k;
    goal_deg  <= tgt;
    travel_ms <= tms;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    beats_sent++;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) begin
      gap = 0;
    end else if (pick < 90) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 98) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes both duty registers; only called while the block is idle.
  task automatic write_duty_regs(input int zero_val, input int full_val);
    cfg_write <= 1'b1;
    cfg_index <= ssr_pkg::CFG_DUTY_ZERO;
    cfg_data  <= ssr_pkg::DUTY_BITS'(zero_val);
    @(posedge clk);
    cfg_index <= ssr_pkg::CFG_DUTY_FULL;
    cfg_data  <= ssr_pkg::DUTY_BITS'(full_val);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  // Stops offering beats until every expected result is out, then lets the block settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly complete moves followed by the ticks that carry them to the goal, with some
  // interrupted moves and random noise beats mixed in.
  task automatic run_ramps(input int n_beats);
    int count;
    int tgt;
    int goal;
    int dist_deg;
    int per_step;
    int tms;
    int ticks;
    int idle_ticks;
    count = 0;
    while (count < n_beats) begin
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 7) == 0) begin
          tgt = $urandom_range(0, 255);
        end else begin
          tgt = aim + int'($urandom_range(0, 24)) - 12;
          if (tgt < 0) tgt = 0;
          if (tgt > ssr_pkg::MAX_ANGLE) tgt = ssr_pkg::MAX_ANGLE;
        end
        goal     = (tgt > ssr_pkg::MAX_ANGLE) ? ssr_pkg::MAX_ANGLE : tgt;
        dist_deg = (goal > aim) ? goal - aim : aim - goal;
        per_step = (dist_deg > 30) ? $urandom_range(0, 1) : $urandom_range(0, 4);
        if (dist_deg > 0) begin
          tms = dist_deg * per_step + $urandom_range(0, dist_deg - 1);
        end else begin
          tms = $urandom_range(0, 65535);
        end
        ticks = dist_deg * ((per_step == 0) ? 1 : per_step);
        // Sometimes cut the ramp short so the next move restarts it.
        if (ticks > 0 && $urandom_range(0, 5) == 0) begin
          ticks = $urandom_range(0, ticks - 1);
        end
        send_beat(ssr_pkg::KIND_MOVE, ssr_pkg::ANGLE_W'(tgt), ssr_pkg::TIME_W'(tms));
        aim = goal;
        repeat (ticks) begin
          send_beat(ssr_pkg::KIND_TICK, ssr_pkg::ANGLE_W'($urandom),
                    ssr_pkg::TIME_W'($urandom));
        end
        // Trailing ticks while idle are ignored by the block and not counted.
        idle_ticks = $urandom_range(0, 2);
        repeat (idle_ticks) begin
          send_beat(ssr_pkg::KIND_TICK, ssr_pkg::ANGLE_W'($urandom),
                    ssr_pkg::TIME_W'($urandom));
        end
        count += 1 + ticks;
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          tgt = $urandom_range(0, 255);
          send_beat(ssr_pkg::KIND_MOVE, ssr_pkg::ANGLE_W'(tgt), ssr_pkg::TIME_W'($urandom));
          aim = (tgt > ssr_pkg::MAX_ANGLE) ? ssr_pkg::MAX_ANGLE : tgt;
        end else begin
          send_beat(ssr_pkg::KIND_TICK, ssr_pkg::ANGLE_W'($urandom),
                    ssr_pkg::TIME_W'($urandom));
        end
        count++;
      end
    end
  endtask

  // Main sequence: reset, directed beats, then random ramps under several register settings.
  initial begin : stimulus
    int zero_val;
    int full_val;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Tick while idle, then a move to the present angle.
    send_beat(ssr_pkg::KIND_TICK, 8'hFF, 16'hFFFF);
    send_beat(ssr_pkg::KIND_MOVE, 8'd0, 16'd500);
    // Zero step delay: one degree per tick.
    send_beat(ssr_pkg::KIND_MOVE, 8'd3, 16'd0);
    repeat (3) send_beat(ssr_pkg::KIND_TICK, 8'h00, 16'h0000);
    // Step delay of one.
    send_beat(ssr_pkg::KIND_MOVE, 8'd5, 16'd2);
    repeat (2) send_beat(ssr_pkg::KIND_TICK, 8'hFF, 16'hFFFF);
    // Clamped goal with the longest time; ticks only count, then a new move restarts.
    send_beat(ssr_pkg::KIND_MOVE, 8'hFF, 16'hFFFF);
    repeat (2) send_beat(ssr_pkg::KIND_TICK, 8'h00, 16'h0000);
    send_beat(ssr_pkg::KIND_MOVE, 8'd4, 16'd3);
    repeat (3) send_beat(ssr_pkg::KIND_TICK, 8'h5A, 16'hA5A5);
    // Downward ramp back to zero.
    send_beat(ssr_pkg::KIND_MOVE, 8'd0, 16'd0);
    repeat (4) send_beat(ssr_pkg::KIND_TICK, 8'hA5, 16'h5A5A);
    aim = 0;
    wait_for_results();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin zero_val = 0;                        full_val = 16383; end
        1: begin zero_val = 16383;                    full_val = 0; end
        2: begin zero_val = $urandom_range(0, 16383); full_val = $urandom_range(0, 16383); end
        3: begin zero_val = 410;                      full_val = 2048; end
        4: begin zero_val = 12000;                    full_val = 3; end
        5: begin zero_val = 16383;                    full_val = 16383; end
        default: begin zero_val = 0;                  full_val = 0; end
      endcase
      write_duty_regs(zero_val, full_val);
      if (ph == 3) begin
        // Long output hold while beats keep coming, so the block backs up.
        quiet     = 1'b1;
        long_hold = 1'b1;
        run_ramps(40);
        quiet = 1'b0;
        run_ramps(60);
      end else begin
        quiet = (ph == 5);
        run_ramps(100);
        quiet = 1'b0;
      end
      wait_for_results();
    end

    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    repeat (2) @(posedge clk);

    $display("Run covered %0d input beats and %0d checked results", beats_sent, checked_count);
    $display("over %0d duty register settings, with random stalls and one long output hold.",
             settings_run);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
